// File: src/srgb_to_cielab_pixel_macros.svh
// ---------------------------------------------------------------------------
// srgb_to_cielab_pixel assertion macros
// Shared concurrent assertion forms, clocked on clock and gated by reset.
// ---------------------------------------------------------------------------
`ifndef SRGB_TO_CIELAB_PIXEL_MACROS_SVH
`define SRGB_TO_CIELAB_PIXEL_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define S2L_ASSERT(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// When ante holds, cons must hold in the next cycle.
`define S2L_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/s2lab_pkg.sv
// ---------------------------------------------------------------------------
// s2lab_pkg
// Types, constants and the sRGB linearization table for the Lab converter.
// ---------------------------------------------------------------------------
package s2lab_pkg;

   localparam int FX_BITS    = 20;
   localparam int DIV_STEPS  = 38;
   localparam int ROOT_STEPS = 26;

   typedef logic [1:0]  csr_addr_type;
   typedef logic [16:0] white_type;
   typedef logic [20:0] lin_type;
   typedef lin_type     lin_table_type [256];

   localparam csr_addr_type REG_WHITE_X = 2'd0;
   localparam csr_addr_type REG_WHITE_Y = 2'd1;
   localparam csr_addr_type REG_WHITE_Z = 2'd2;

   localparam white_type WHITE_X_RESET = 17'd62289;
   localparam white_type WHITE_Y_RESET = 17'd65536;
   localparam white_type WHITE_Z_RESET = 17'd71352;

   // sRGB to XYZ matrix, scaled by 10^7; rows give X, Y, Z.
   localparam logic [23:0] MATRIX_K [3][3] = '{
      '{24'd4124564, 24'd3575761, 24'd1804375},
      '{24'd2126729, 24'd7151522, 24'd721750},
      '{24'd193339,  24'd1191920, 24'd9503041}
   };

   localparam logic [43:0] XYZ_HALF     = 44'd5000000;
   localparam logic [16:0] DIV_78125    = 17'd78125;
   localparam logic [23:0] RECIP_78125  = 24'd14073748;
   localparam logic [24:0] DIV_145      = 25'd145;
   localparam logic [24:0] RECIP_145    = 25'd29620464;
   localparam logic [37:0] CURVE_KNEE   = 38'd9287;
   localparam logic [27:0] CURVE_SLOPE  = 28'd9033;
   localparam logic [27:0] CURVE_OFFSET = 28'd167772740;

   // Builds the Q20 linear value of every 8-bit code. The power branch uses
   // u^2.4 = u^2 * (u^2)^(1/5) with a bitwise fifth-root search.
   function automatic lin_table_type build_lin_table();
      lin_table_type tbl;
      logic [63:0]   c;
      logic [63:0]   u;
      logic [63:0]   w;
      logic [63:0]   z;
      logic [63:0]   cand;
      logic [63:0]   p;
      for (int i = 0; i < 256; i++) begin
         c = 64'(i);
         if (c * 64'd100000 > 64'd1031475) begin
            u = (((64'd1000 * c + 64'd14025) << 20) + 64'd134512) / 64'd269025;
            w = (u * u + 64'd524288) >> 20;
            z = '0;
            for (int bt = 20; bt >= 0; bt--) begin
               cand = z | (64'd1 << bt);
               p = cand;
               for (int k = 0; k < 4; k++) begin
                  p = (p * cand) >> 20;
               end
               if (p <= w) begin
                  z = cand;
               end
            end
            tbl[i] = lin_type'((w * z + 64'd524288) >> 20);
         end else begin
            tbl[i] = lin_type'(((c << 20) * 64'd100 + 64'd164730) / 64'd329460);
         end
      end
      return tbl;
   endfunction

   localparam lin_table_type LIN_TABLE = build_lin_table();

endpackage

// File: src/srgb_to_cielab_pixel.sv
// ---------------------------------------------------------------------------
// srgb_to_cielab_pixel
// Converts one 8-bit sRGB pixel per unstalled clock to CIELAB L, a, b fixed point.
// ---------------------------------------------------------------------------
//  Channel  Ports       Payload
//  req      req_t*      red, green, blue in tdata; last_pixel in tlast
//  rsp      rsp_t*      lightness, green_red, blue_yellow; last_out in tlast
//  csr      csr_*       write-only white point registers, index 0..2
//
// One pixel enters per clock while the pipeline is not held. The pipeline
// has 102 register stages; the depth is set by the 38-step restoring
// divider and the 26-bit cube root search (two stages per bit). The whole
// pipeline holds when the result register is full and not taken. Reset
// clears the valid line and loads the D65 white point.
// ---------------------------------------------------------------------------
module srgb_to_cielab_pixel #(
   parameter int LAB_FRAC_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [23:0]             req_tdata,  // red[7:0], green[15:8], blue[23:16]
   input  logic                    req_tlast,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [47:0]             rsp_tdata,  // lightness[14:0], green_red[30:15],
                                               // blue_yellow[46:31], zero pad
   output logic                    rsp_tlast,
   input  logic                    csr_wen,
   input  s2lab_pkg::csr_addr_type csr_addr,
   input  s2lab_pkg::white_type    csr_wdata
);
   import s2lab_pkg::*;

   localparam int SHIFT      = FX_BITS - LAB_FRAC_BITS;
   localparam int PIPE_DEPTH = 7 + DIV_STEPS + 2 * ROOT_STEPS + 5;
   localparam logic [36:0] ROUND_HALF = 37'(1) << (SHIFT - 1);

   white_type white_ff [3];
   logic      pipe_en;

   logic [PIPE_DEPTH-1:0] valid_ff;
   logic [PIPE_DEPTH-1:0] last_ff;

   lin_type     lin_ff   [3];
   logic [44:0] prod_ff  [3][3];
   logic [43:0] sum_ff   [3];
   logic [36:0] sp_ff    [3];
   logic [36:0] sp_d_ff  [3];
   logic [36:0] sp_dd_ff [3];
   logic [20:0] q0_ff    [3];
   logic [20:0] q0_d_ff  [3];
   logic [37:0] pr_ff    [3];
   logic [20:0] xyz_ff   [3];

   white_type   div_white [3];
   logic [37:0] div_num   [3];
   logic [16:0] div_rem_ff [DIV_STEPS][3];
   logic [37:0] div_nq_ff  [DIV_STEPS][3];

   logic [37:0] ra_t_ff    [ROOT_STEPS][3];
   logic [25:0] ra_z_ff    [ROOT_STEPS][3];
   logic [51:0] ra_zsq_ff  [ROOT_STEPS][3];
   logic [25:0] ra_cand_ff [ROOT_STEPS][3];
   logic [51:0] ra_csq_ff  [ROOT_STEPS][3];
   logic [37:0] rb_t_ff    [ROOT_STEPS][3];
   logic [25:0] rb_z_ff    [ROOT_STEPS][3];
   logic [51:0] rb_zsq_ff  [ROOT_STEPS][3];

   logic        f1_big_ff [3];
   logic [25:0] f1_z_ff   [3];
   logic [27:0] f1_n_ff   [3];
   logic        f2_big_ff [3];
   logic [25:0] f2_z_ff   [3];
   logic [24:0] f2_np_ff  [3];
   logic [17:0] f2_q0_ff  [3];
   logic [25:0] f3_f_ff   [3];

   logic signed [36:0] lq_ff;
   logic signed [36:0] aq_ff;
   logic signed [36:0] bq_ff;
   logic [14:0] out_l_ff;
   logic [15:0] out_a_ff;
   logic [15:0] out_b_ff;

   // -------------------------------------------------------------------------
   // Configuration registers and flow control
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         white_ff[0] <= WHITE_X_RESET;
         white_ff[1] <= WHITE_Y_RESET;
         white_ff[2] <= WHITE_Z_RESET;
      end else if (csr_wen) begin
         unique case (csr_addr)
            REG_WHITE_X: white_ff[0] <= csr_wdata;
            REG_WHITE_Y: white_ff[1] <= csr_wdata;
            REG_WHITE_Z: white_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign pipe_en    = !valid_ff[PIPE_DEPTH-1] || rsp_tready;
   assign req_tready = pipe_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (pipe_en) begin
         valid_ff <= {valid_ff[PIPE_DEPTH-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         last_ff <= {last_ff[PIPE_DEPTH-2:0], req_tlast};
      end
   end

   // -------------------------------------------------------------------------
   // Linearize, matrix, exact division by 10^7
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         lin_ff[0] <= LIN_TABLE[req_tdata[7:0]];
         lin_ff[1] <= LIN_TABLE[req_tdata[15:8]];
         lin_ff[2] <= LIN_TABLE[req_tdata[23:16]];
      end
   end

   for (genvar ch = 0; ch < 3; ch++) begin : g_xyz
      logic [44:0] q0_prod;
      logic [36:0] rem_full;
      logic [19:0] rem;
      logic [20:0] q_in;

      always_comb begin
         q0_prod  = 45'(sp_ff[ch][36:16]) * 45'(RECIP_78125);
         rem_full = sp_dd_ff[ch] - pr_ff[ch][36:0];
         rem      = rem_full[19:0];
         // The reciprocal estimate runs low by at most a few counts.
         q_in = q0_d_ff[ch]
              + 21'(rem >= 20'(DIV_78125))
              + 21'(rem >= 20'(2 * DIV_78125))
              + 21'(rem >= 20'(3 * DIV_78125));
      end

      always_ff @(posedge clock) begin
         if (pipe_en) begin
            for (int k = 0; k < 3; k++) begin
               prod_ff[ch][k] <= 45'(lin_ff[k]) * 45'(MATRIX_K[ch][k]);
            end
            sum_ff[ch]   <= prod_ff[ch][0][43:0] + prod_ff[ch][1][43:0]
                          + prod_ff[ch][2][43:0] + XYZ_HALF;
            sp_ff[ch]    <= sum_ff[ch][43:7];
            q0_ff[ch]    <= q0_prod[44:24];
            pr_ff[ch]    <= 38'(q0_ff[ch]) * 38'(DIV_78125);
            q0_d_ff[ch]  <= q0_ff[ch];
            sp_d_ff[ch]  <= sp_ff[ch];
            sp_dd_ff[ch] <= sp_d_ff[ch];
            xyz_ff[ch]   <= q_in;
         end
      end

      // -----------------------------------------------------------------------
      // Ratio to the white point: restoring divider, one bit a stage
      // -----------------------------------------------------------------------
      assign div_white[ch] = (white_ff[ch] == '0) ? 17'd1 : white_ff[ch];
      assign div_num[ch]   = {1'b0, xyz_ff[ch], 16'b0} + 38'(div_white[ch] >> 1);

      for (genvar st = 0; st < DIV_STEPS; st++) begin : g_div
         logic [16:0] rem_src;
         logic [37:0] nq_src;
         logic [17:0] trial;
         logic [16:0] rem_in;
         logic [37:0] nq_in;

         if (st == 0) begin : g_first
            assign rem_src = '0;
            assign nq_src  = div_num[ch];
         end else begin : g_next
            assign rem_src = div_rem_ff[st-1][ch];
            assign nq_src  = div_nq_ff[st-1][ch];
         end

         always_comb begin
            trial = {rem_src, nq_src[37]};
            if (trial >= {1'b0, div_white[ch]}) begin
               rem_in = 17'(trial - {1'b0, div_white[ch]});
               nq_in  = {nq_src[36:0], 1'b1};
            end else begin
               rem_in = trial[16:0];
               nq_in  = {nq_src[36:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            if (pipe_en) begin
               div_rem_ff[st][ch] <= rem_in;
               div_nq_ff[st][ch]  <= nq_in;
            end
         end
      end

      // -----------------------------------------------------------------------
      // Cube root search: candidate square by adds, then one product a bit
      // -----------------------------------------------------------------------
      for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_root
         localparam int BIT = ROOT_STEPS - 1 - j;
         logic [37:0] t_src;
         logic [25:0] z_src;
         logic [51:0] zsq_src;
         logic [57:0] prod;
         logic        hit;

         if (j == 0) begin : g_first
            assign t_src   = div_nq_ff[DIV_STEPS-1][ch];
            assign z_src   = '0;
            assign zsq_src = '0;
         end else begin : g_next
            assign t_src   = rb_t_ff[j-1][ch];
            assign z_src   = rb_z_ff[j-1][ch];
            assign zsq_src = rb_zsq_ff[j-1][ch];
         end

         always_comb begin
            prod = 58'(ra_csq_ff[j][ch][51:20]) * 58'(ra_cand_ff[j][ch]);
            hit  = prod[57:20] <= ra_t_ff[j][ch];
         end

         always_ff @(posedge clock) begin
            if (pipe_en) begin
               ra_t_ff[j][ch]    <= t_src;
               ra_z_ff[j][ch]    <= z_src;
               ra_zsq_ff[j][ch]  <= zsq_src;
               ra_cand_ff[j][ch] <= z_src | (26'd1 << BIT);
               // Bits of z lie above BIT, so (z + 2^BIT)^2 expands exactly.
               ra_csq_ff[j][ch]  <= zsq_src + (52'(z_src) << (BIT + 1))
                                  + (52'd1 << (2 * BIT));
               rb_t_ff[j][ch]    <= ra_t_ff[j][ch];
               rb_z_ff[j][ch]    <= hit ? ra_cand_ff[j][ch] : ra_z_ff[j][ch];
               rb_zsq_ff[j][ch]  <= hit ? ra_csq_ff[j][ch] : ra_zsq_ff[j][ch];
            end
         end
      end

      // -----------------------------------------------------------------------
      // Linear segment below the knee, exact division by 1160
      // -----------------------------------------------------------------------
      logic [37:0] t_done;
      logic [49:0] lin_q_prod;
      logic [25:0] lin_qm;
      logic [24:0] lin_rem;

      assign t_done = rb_t_ff[ROOT_STEPS-1][ch];

      always_comb begin
         lin_q_prod = 50'(f1_n_ff[ch][27:3]) * 50'(RECIP_145);
         lin_qm     = 26'(f2_q0_ff[ch]) * 26'(DIV_145);
         lin_rem    = 25'(26'(f2_np_ff[ch]) - lin_qm);
      end

      always_ff @(posedge clock) begin
         if (pipe_en) begin
            f1_big_ff[ch] <= t_done >= CURVE_KNEE;
            f1_z_ff[ch]   <= rb_z_ff[ROOT_STEPS-1][ch];
            f1_n_ff[ch]   <= 28'(t_done[13:0]) * CURVE_SLOPE + CURVE_OFFSET;
            f2_big_ff[ch] <= f1_big_ff[ch];
            f2_z_ff[ch]   <= f1_z_ff[ch];
            f2_np_ff[ch]  <= f1_n_ff[ch][27:3];
            f2_q0_ff[ch]  <= lin_q_prod[49:32];
            f3_f_ff[ch]   <= f2_big_ff[ch] ? f2_z_ff[ch]
                           : 26'(f2_q0_ff[ch]) + 26'(lin_rem >= DIV_145);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Lab combination, rounding half away from zero, saturation
   // -------------------------------------------------------------------------
   function automatic logic [36:0] round_mag(logic signed [36:0] v);
      logic [36:0] mag;
      mag = v[36] ? 37'(-v) : 37'(v);
      return (mag + ROUND_HALF) >> SHIFT;
   endfunction

   function automatic logic [15:0] sat_signed(logic signed [36:0] v);
      logic [36:0] rm;
      rm = round_mag(v);
      if (v[36]) begin
         return (rm > 37'd32768) ? 16'h8000 : 16'(37'd0 - rm);
      end
      return (rm > 37'd32767) ? 16'h7FFF : rm[15:0];
   endfunction

   function automatic logic [14:0] sat_lightness(logic signed [36:0] v);
      logic [36:0] rm;
      rm = round_mag(v);
      if (v[36]) begin
         return '0;
      end
      return (rm > 37'd32767) ? 15'h7FFF : rm[14:0];
   endfunction

   logic signed [36:0] fx_s;
   logic signed [36:0] fy_s;
   logic signed [36:0] fz_s;

   assign fx_s = $signed({11'b0, f3_f_ff[0]});
   assign fy_s = $signed({11'b0, f3_f_ff[1]});
   assign fz_s = $signed({11'b0, f3_f_ff[2]});

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         lq_ff    <= fy_s * 37'sd116 - 37'sd16777216;
         aq_ff    <= (fx_s - fy_s) * 37'sd500;
         bq_ff    <= (fy_s - fz_s) * 37'sd200;
         out_l_ff <= sat_lightness(lq_ff);
         out_a_ff <= sat_signed(aq_ff);
         out_b_ff <= sat_signed(bq_ff);
      end
   end

   assign rsp_tvalid = valid_ff[PIPE_DEPTH-1];
   assign rsp_tlast  = last_ff[PIPE_DEPTH-1];
   assign rsp_tdata  = {1'b0, out_b_ff, out_a_ff, out_l_ff};

   // -------------------------------------------------------------------------
   // Assertions
   // -------------------------------------------------------------------------
`include "srgb_to_cielab_pixel_macros.svh"

   `S2L_ASSERT_NEXT(a_stall_holds, !pipe_en, $stable(valid_ff) && $stable(rsp_tdata), "output moved in a stall")
   `S2L_ASSERT_NEXT(a_accept_enters, req_tvalid && req_tready, valid_ff[0], "accepted transaction lost")
   `S2L_ASSERT(a_free_when_empty, !rsp_tvalid |-> req_tready, "input blocked while output empty")

endmodule
